// ===== design/wcm_pkg.sv =====
// ----------------------------------------------------------------------------
// wcm_pkg
// shared types, widths and codes of the word concatenation window matcher
// ----------------------------------------------------------------------------
package wcm_pkg;

  localparam int CNT_W      = 5;
  localparam int LEN_W      = 4;
  localparam int WORD_W     = 64;
  localparam int CH_W       = 8;
  localparam int FUNC_W     = 2;
  localparam int OUT_W      = 32;
  localparam int IN_DATA_W  = WORD_W + CH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_COUNT = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD = 2'd0,
    FN_TEXT = 2'd1,
    FN_NEW  = 2'd2
  } func_t;

  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] key;
  } dict_req_t;

  function automatic logic [WORD_W-1:0] word_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      if (LEN_W'(b) < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== design/word_concatenation_window_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// word_concatenation_window_matcher_unit
// finds every text position where word_count back-to-back dictionary words
// occur, multiplicities included
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel and sustains that rate with no
// bubbles while out_tready does not stall the output; a text byte's result
// passes the input register, the window update and the result register. The
// rate is set by the per-word update: a parallel compare against all
// dictionary entries, one count lane per entry indexed by phase, and the slot
// store whose old word id is read ahead from its registered read port. The slot
// store has no clearing pass and no reset; the block is ready right after reset.
module word_concatenation_window_matcher_unit #(
  parameter int MAX_WORDS    = 16,
  parameter int MAX_WORD_LEN = 8,
  parameter int POS_WIDTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wcm_pkg::IN_DATA_W-1:0]     in_tdata,   // pattern_word, ch
  input  logic [wcm_pkg::FUNC_W-1:0]        in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wcm_pkg::OUT_W-1:0]         out_tdata,  // match_start
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wcm_pkg::*;

  localparam int IDW     = $clog2(MAX_WORDS + 1);
  localparam int PTR_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PH_W    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int SLOT_AW = PH_W + PTR_W;
  localparam int EXT_W   = (POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W;
  localparam logic [IDW-1:0] NO_WORD = IDW'(MAX_WORDS);

  // input stage
  logic                 s_valid_r;
  logic [FUNC_W-1:0]    s_func_r;
  logic [WORD_W-1:0]    s_word_r;
  logic [CH_W-1:0]      s_ch_r;

  // configuration
  logic [LEN_W-1:0]     word_len_r;
  logic [CNT_W-1:0]     word_count_r;
  logic [LEN_W-1:0]     len_eff;
  logic [CNT_W-1:0]     wc_eff;

  // text state
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [WORD_W-1:0]    recent_r, recent_nxt;
  logic [PH_W-1:0]      phase_r, phase_nxt;
  logic [PTR_W-1:0]     ring_ptr_r [MAX_WORD_LEN];
  logic [PTR_W-1:0]     ring_ptr_nxt [MAX_WORD_LEN];
  logic [CNT_W-1:0]     ring_cnt_r [MAX_WORD_LEN];
  logic [CNT_W-1:0]     ring_cnt_nxt [MAX_WORD_LEN];
  logic [CNT_W-1:0]     ring_mat_r [MAX_WORD_LEN];
  logic [CNT_W-1:0]     ring_mat_nxt [MAX_WORD_LEN];
  logic [CNT_W-1:0]     lc_r [MAX_WORDS][MAX_WORD_LEN];

  // slot store
  logic [IDW-1:0]       slot_mem [2**SLOT_AW];
  logic [IDW-1:0]       slot_rd_r;
  logic [SLOT_AW-1:0]   wr_addr, rd_addr;

  // output register
  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_start_r;

  // update logic
  logic                 adv, go, text_go, word_go, clear, cfg_clear;
  logic [WORD_W-1:0]    text_word;
  logic [LEN_W-1:0]     src;
  dict_req_t            dreq;
  logic [IDW-1:0]       hit_id;
  logic [MAX_WORDS-1:0][CNT_W-1:0] mult;
  logic [CNT_W-1:0]     lane_c2 [MAX_WORDS];
  logic [CNT_W-1:0]     lane_c, lane_c1;
  logic [MAX_WORDS-1:0] inc_v, dec_v;
  logic                 wrapped, span_ok, dec_en, ptr_wrap, match_hit;
  logic [PTR_W-1:0]     ptr_new;
  logic [CNT_W-1:0]     cnt_new, mat_m1, mat_new;
  logic [8:0]           span;
  logic [POS_WIDTH-1:0] j_pos;
  logic [EXT_W-1:0]     start_ext;

  assign cfg_ready  = 1'b1;
  assign adv        = !out_valid_r || out_tready;
  assign go         = s_valid_r && adv;
  assign in_tready  = !s_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_start_r;
  assign cfg_clear  = cfg_valid && (cfg_index == CFG_WORD_LEN || cfg_index == CFG_WORD_COUNT);

  always_comb begin
    if (word_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(word_len_r) > MAX_WORD_LEN) begin
      len_eff = LEN_W'(MAX_WORD_LEN);
    end else begin
      len_eff = word_len_r;
    end
    if (word_count_r == '0) begin
      wc_eff = CNT_W'(1);
    end else if (int'(word_count_r) > MAX_WORDS) begin
      wc_eff = CNT_W'(MAX_WORDS);
    end else begin
      wc_eff = word_count_r;
    end
  end

  always_comb begin
    text_go = go && (s_func_r == FN_TEXT) && (pos_r != '1);
    word_go = text_go && (pos_r >= POS_WIDTH'(len_eff) - POS_WIDTH'(1));
    clear   = (go && s_func_r == FN_NEW) || cfg_clear;

    recent_nxt = {s_ch_r, recent_r[WORD_W-1:CH_W]};
    text_word  = '0;
    src        = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      if (LEN_W'(b) < len_eff) begin
        src = LEN_W'(WORD_W / 8 + b) - len_eff;
        text_word[8*b +: 8] = recent_nxt[{src[2:0], 3'b000} +: 8];
      end
    end

    dreq.load = go && (s_func_r == FN_LOAD);
    dreq.key  = (s_func_r == FN_LOAD) ? s_word_r : text_word;
  end

  wcm_dict #(
    .MAX_WORDS (MAX_WORDS)
  ) u_dict (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (dreq),
    .len    (len_eff),
    .hit_id (hit_id),
    .mult   (mult)
  );

  // per-word window update for the phase at the head of the ring
  always_comb begin
    wrapped = ring_cnt_r[0] >= wc_eff;
    span_ok = ({1'b0, ring_cnt_r[0]} + 6'd1) >= {1'b0, wc_eff};
    dec_en  = wrapped && (slot_rd_r < NO_WORD);
    lane_c  = '0;
    lane_c1 = '0;
    for (int i = 0; i < MAX_WORDS; i++) begin
      lane_c  = lc_r[i][phase_r];
      lane_c1 = (hit_id == IDW'(i) && lane_c != CNT_MAX) ? lane_c + CNT_W'(1) : lane_c;
      inc_v[i] = (hit_id == IDW'(i)) && (lane_c1 <= mult[i]);
      dec_v[i] = dec_en && (slot_rd_r == IDW'(i)) && (lane_c1 <= mult[i]);
      lane_c2[i] = (dec_en && slot_rd_r == IDW'(i) && lane_c1 != '0) ?
                   lane_c1 - CNT_W'(1) : lane_c1;
    end

    mat_m1  = (|inc_v && ring_mat_r[0] != CNT_MAX) ? ring_mat_r[0] + CNT_W'(1) :
              ring_mat_r[0];
    mat_new = (|dec_v && mat_m1 != '0) ? mat_m1 - CNT_W'(1) : mat_m1;

    ptr_wrap = (32'(ring_ptr_r[0]) + 32'd1) == 32'(wc_eff);
    ptr_new  = ptr_wrap ? '0 : ring_ptr_r[0] + PTR_W'(1);
    cnt_new  = (ring_cnt_r[0] != CNT_MAX) ? ring_cnt_r[0] + CNT_W'(1) : ring_cnt_r[0];

    j_pos     = pos_r - (POS_WIDTH'(len_eff) - POS_WIDTH'(1));
    span      = 9'(wc_eff - CNT_W'(1)) * 9'(len_eff);
    start_ext = EXT_W'(j_pos - POS_WIDTH'(span));
    match_hit = word_go && (mat_new == wc_eff) && span_ok;
  end

  // next state of the text registers and the phase ring
  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      ring_ptr_nxt[k] = ring_ptr_r[k];
      ring_cnt_nxt[k] = ring_cnt_r[k];
      ring_mat_nxt[k] = ring_mat_r[k];
    end
    if (clear) begin
      pos_nxt   = '0;
      phase_nxt = '0;
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        ring_ptr_nxt[k] = '0;
        ring_cnt_nxt[k] = '0;
        ring_mat_nxt[k] = '0;
      end
    end else begin
      if (text_go) begin
        pos_nxt = pos_r + POS_WIDTH'(1);
      end
      if (word_go) begin
        phase_nxt = ((32'(phase_r) + 32'd1) == 32'(len_eff)) ? '0 : phase_r + PH_W'(1);
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
          if (k + 1 == int'(len_eff)) begin
            ring_ptr_nxt[k] = ptr_new;
            ring_cnt_nxt[k] = cnt_new;
            ring_mat_nxt[k] = mat_new;
          end else begin
            ring_ptr_nxt[k] = ring_ptr_r[(k + 1) % MAX_WORD_LEN];
            ring_cnt_nxt[k] = ring_cnt_r[(k + 1) % MAX_WORD_LEN];
            ring_mat_nxt[k] = ring_mat_r[(k + 1) % MAX_WORD_LEN];
          end
        end
      end
    end
    wr_addr = {phase_r, ring_ptr_r[0]};
    rd_addr = {phase_nxt, ring_ptr_nxt[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      word_len_r   <= LEN_W'(1);
      word_count_r <= CNT_W'(1);
      pos_r        <= '0;
      recent_r     <= '0;
      phase_r      <= '0;
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        ring_ptr_r[k] <= '0;
        ring_cnt_r[k] <= '0;
        ring_mat_r[k] <= '0;
      end
      for (int i = 0; i < MAX_WORDS; i++) begin
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
          lc_r[i][k] <= '0;
        end
      end
    end else begin
      if (in_tvalid && in_tready) begin
        s_valid_r <= 1'b1;
      end else if (go) begin
        s_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= match_hit;
      end
      if (cfg_valid && cfg_index == CFG_WORD_LEN) begin
        word_len_r <= cfg_data[LEN_W-1:0];
      end
      if (cfg_valid && cfg_index == CFG_WORD_COUNT) begin
        word_count_r <= cfg_data[CNT_W-1:0];
      end
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      if (clear) begin
        recent_r <= '0;
      end else if (text_go) begin
        recent_r <= recent_nxt;
      end
      for (int k = 0; k < MAX_WORD_LEN; k++) begin
        ring_ptr_r[k] <= ring_ptr_nxt[k];
        ring_cnt_r[k] <= ring_cnt_nxt[k];
        ring_mat_r[k] <= ring_mat_nxt[k];
      end
      for (int i = 0; i < MAX_WORDS; i++) begin
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
          if (clear) begin
            lc_r[i][k] <= '0;
          end else if (word_go && phase_r == PH_W'(k)) begin
            lc_r[i][k] <= lane_c2[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_func_r <= in_tuser;
      s_word_r <= in_tdata[WORD_W-1:0];
      s_ch_r   <= in_tdata[IN_DATA_W-1:WORD_W];
    end
    if (adv) begin
      out_start_r <= start_ext[OUT_W-1:0];
    end
  end

  // slot store, read one word ahead at the next head slot
  always_ff @(posedge clk) begin
    if (word_go) begin
      slot_mem[wr_addr] <= hit_id;
    end
    if (word_go && wr_addr == rd_addr) begin
      slot_rd_r <= hit_id;
    end else begin
      slot_rd_r <= slot_mem[rd_addr];
    end
  end

endmodule

// ===== design/wcm_dict.sv =====
// ----------------------------------------------------------------------------
// wcm_dict
// dictionary store: parallel lookup of one key, word loading and multiplicities
// ----------------------------------------------------------------------------
module wcm_dict #(
  parameter int MAX_WORDS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  wcm_pkg::dict_req_t                         req,
  input  logic [wcm_pkg::LEN_W-1:0]                  len,
  output logic [$clog2(MAX_WORDS+1)-1:0]             hit_id,
  output logic [MAX_WORDS-1:0][wcm_pkg::CNT_W-1:0]   mult
);
  import wcm_pkg::*;

  localparam int IDW = $clog2(MAX_WORDS + 1);
  localparam logic [IDW-1:0] NO_WORD = IDW'(MAX_WORDS);

  logic [WORD_W-1:0]                entry_r [MAX_WORDS];
  logic [MAX_WORDS-1:0][CNT_W-1:0]  mult_r;
  logic [IDW-1:0]                   used_r;
  logic [WORD_W-1:0]                mask;
  logic [MAX_WORDS-1:0]             hit;
  logic                             add_new;

  always_comb begin
    mask   = word_mask(len);
    hit_id = NO_WORD;
    for (int i = 0; i < MAX_WORDS; i++) begin
      hit[i] = (IDW'(i) < used_r) && (((entry_r[i] ^ req.key) & mask) == '0);
    end
    // lowest matching entry wins
    for (int i = MAX_WORDS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_id = IDW'(i);
      end
    end
    add_new = req.load && (hit_id == NO_WORD) && (used_r < NO_WORD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= '0;
      used_r <= '0;
    end else if (req.load) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        if (hit_id == IDW'(i) && mult_r[i] != CNT_MAX) begin
          mult_r[i] <= mult_r[i] + CNT_W'(1);
        end else if (add_new && used_r == IDW'(i)) begin
          mult_r[i] <= CNT_W'(1);
        end
      end
      if (add_new) begin
        used_r <= used_r + IDW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WORDS; i++) begin
      if (add_new && used_r == IDW'(i)) begin
        entry_r[i] <= req.key;
      end
    end
  end

  assign mult = mult_r;

endmodule
